// File: rtl/mt_pkg.sv
// Package: types, constants and tempering function for the MT19937 generator.
`default_nettype none

package mt_pkg;

    localparam int MT_STATE_WORDS  = 624;
    localparam int MT_TWIST_OFFSET = 397;
    localparam int MT_WORD_W       = 32;

    localparam logic [MT_WORD_W-1:0] MT_MULT    = 32'd1812433253;
    localparam logic [MT_WORD_W-1:0] MT_MATRIX  = 32'h9908b0df;
    localparam logic [MT_WORD_W-1:0] MT_UPPER   = 32'h80000000;
    localparam logic [MT_WORD_W-1:0] MT_LOWER   = 32'h7fffffff;
    localparam logic [MT_WORD_W-1:0] MT_TEMPER_B = 32'h9d2c5680;
    localparam logic [MT_WORD_W-1:0] MT_TEMPER_C = 32'hefc60000;

    localparam int MT_SEED_SHIFT = 30;
    localparam int MT_TEMPER_U   = 11;
    localparam int MT_TEMPER_S   = 7;
    localparam int MT_TEMPER_T   = 15;
    localparam int MT_TEMPER_L   = 18;

    typedef enum logic {
        OP_DRAW   = 1'b0,
        OP_RESEED = 1'b1
    } op_t;

    typedef struct packed {
        logic                 req_type;
        logic [MT_WORD_W-1:0] seed;
    } req_t;

    typedef struct packed {
        logic [MT_WORD_W-1:0] random_word;
        logic                 seeded;
    } rsp_t;

    typedef struct packed {
        op_t                  op;
        logic [MT_WORD_W-1:0] seed;
    } cmd_t;

    function automatic logic [MT_WORD_W-1:0] temper(input logic [MT_WORD_W-1:0] w);
        logic [MT_WORD_W-1:0] y;
        y = w ^ (w >> MT_TEMPER_U);
        y = y ^ ((y << MT_TEMPER_S) & MT_TEMPER_B);
        y = y ^ ((y << MT_TEMPER_T) & MT_TEMPER_C);
        y = y ^ (y >> MT_TEMPER_L);
        return y;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mt_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module mt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// File: rtl/mt_front.sv
// Front end: accepts request beats, classifies them and queues them for the engine.
`default_nettype none

module mt_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire mt_pkg::req_t req,
    output logic              cmd_valid,
    input  wire logic         cmd_ready,
    output mt_pkg::cmd_t      cmd
);

    import mt_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;
    cmd_t             cmd_in;

    assign busy      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = start && !busy;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        cmd_in.op   = req.req_type ? OP_RESEED : OP_DRAW;
        cmd_in.seed = req.seed;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/mt_back.sv
// Back end: seeding, twist sweep and tempered draw sequencer over the state RAM.
`default_nettype none

module mt_back #(
    parameter int STATE_WORDS  = mt_pkg::MT_STATE_WORDS,
    parameter int TWIST_OFFSET = mt_pkg::MT_TWIST_OFFSET
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire mt_pkg::cmd_t                     cmd,
    output logic                                  ram_we,
    output logic [$clog2(STATE_WORDS)-1:0]        ram_waddr,
    output logic [mt_pkg::MT_WORD_W-1:0]          ram_wdata,
    output logic [$clog2(STATE_WORDS)-1:0]        ram_raddr_a,
    output logic [$clog2(STATE_WORDS)-1:0]        ram_raddr_b,
    input  wire logic [mt_pkg::MT_WORD_W-1:0]     ram_rdata_a,
    input  wire logic [mt_pkg::MT_WORD_W-1:0]     ram_rdata_b,
    output logic                                  done,
    output mt_pkg::rsp_t                          result
);

    import mt_pkg::*;

    localparam int ADDR_W = $clog2(STATE_WORDS);
    localparam int IDX_W  = $clog2(STATE_WORDS + 1);
    localparam int SUM_W  = IDX_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_PRIME,
        S_TWIST,
        S_READ,
        S_OUT
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 have_seed_reg;
    logic [MT_WORD_W-1:0] w_reg;
    logic [MT_WORD_W-1:0] cur_reg;
    logic                 done_reg;
    rsp_t                 result_reg;

    logic [MT_WORD_W-1:0] mix;
    logic [MT_WORD_W-1:0] seed_word;
    logic [MT_WORD_W-1:0] twist_y;
    logic [MT_WORD_W-1:0] twist_word;
    logic [IDX_W-1:0]     cnt_m1;
    logic [IDX_W-1:0]     nxt_idx;
    logic [SUM_W-1:0]     far_sum;
    logic [SUM_W-1:0]     far_idx;

    assign mix       = w_reg ^ (w_reg >> MT_SEED_SHIFT);
    assign seed_word = mix * MT_MULT + MT_WORD_W'(cnt_reg);

    assign twist_y    = (cur_reg & MT_UPPER) | (ram_rdata_a & MT_LOWER);
    assign twist_word = ram_rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : '0);

    assign cnt_m1  = cnt_reg - 1'b1;
    assign nxt_idx = (cnt_reg >= IDX_W'(STATE_WORDS - 1)) ? '0 : cnt_reg + 1'b1;
    assign far_sum = {1'b0, cnt_reg} + SUM_W'(TWIST_OFFSET);
    assign far_idx = (far_sum >= SUM_W'(STATE_WORDS)) ? far_sum - SUM_W'(STATE_WORDS)
                                                      : far_sum;

    assign cmd_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[ADDR_W-1:0];
        ram_wdata   = seed_word;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        case (state_reg)
            S_SEED:
            begin
                ram_we    = 1'b1;
                ram_wdata = (cnt_reg == '0) ? w_reg : seed_word;
            end
            S_TWIST:
            begin
                ram_we      = (cnt_reg != '0);
                ram_waddr   = cnt_m1[ADDR_W-1:0];
                ram_wdata   = twist_word;
                ram_raddr_a = nxt_idx[ADDR_W-1:0];
                ram_raddr_b = (cnt_reg < IDX_W'(STATE_WORDS)) ? far_idx[ADDR_W-1:0] : '0;
            end
            S_READ:
            begin
                ram_raddr_a = idx_reg[ADDR_W-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= IDX_W'(STATE_WORDS);
            have_seed_reg <= 1'b0;
            done_reg      <= 1'b0;
            w_reg         <= '0;
            cur_reg       <= '0;
            result_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.op == OP_RESEED)
                        begin
                            w_reg     <= cmd.seed;
                            cnt_reg   <= '0;
                            state_reg <= S_SEED;
                        end
                        else if (!have_seed_reg)
                        begin
                            result_reg <= '0;
                            done_reg   <= 1'b1;
                        end
                        else if (idx_reg >= IDX_W'(STATE_WORDS))
                        begin
                            state_reg <= S_PRIME;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_SEED:
                begin
                    w_reg   <= ram_wdata;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(STATE_WORDS - 1))
                    begin
                        idx_reg       <= IDX_W'(STATE_WORDS);
                        have_seed_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_PRIME:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_TWIST;
                end
                S_TWIST:
                begin
                    cur_reg <= ram_rdata_a;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IDX_W'(STATE_WORDS))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    result_reg.random_word <= temper(ram_rdata_a);
                    result_reg.seeded      <= 1'b1;
                    done_reg               <= 1'b1;
                    idx_reg                <= idx_reg + 1'b1;
                    state_reg              <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/mersenne_twister_generator.sv
// Top level of the MT19937 generator: front queue, sequencing engine and state RAM.
// Draw: read in S_READ, tempered in S_OUT, one draw at a time; unseeded: zero word, back to back.
// The first draw after a reseed and every 624th after it first twist the state (S_PRIME, S_TWIST).
// Reseed: dispatch, then one seeding multiply per word into the state RAM; no result.
// A 2-beat queue takes requests while the engine works; busy is high only when it is full.
// Reset: queue empty, generator unseeded, state RAM left uncleared; results cannot be stalled.
`default_nettype none

module mersenne_twister_generator #(
    parameter int STATE_WORDS  = mt_pkg::MT_STATE_WORDS,
    parameter int TWIST_OFFSET = mt_pkg::MT_TWIST_OFFSET
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire mt_pkg::req_t req,
    output logic              done,
    output mt_pkg::rsp_t      result
);

    import mt_pkg::*;

    localparam int ADDR_W = $clog2(STATE_WORDS);

    cmd_t                 cmd;
    logic                 cmd_valid;
    logic                 cmd_ready;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [MT_WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr_a;
    logic [ADDR_W-1:0]    ram_raddr_b;
    logic [MT_WORD_W-1:0] ram_rdata_a;
    logic [MT_WORD_W-1:0] ram_rdata_b;

    mt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mt_back #(
        .STATE_WORDS  (STATE_WORDS),
        .TWIST_OFFSET (TWIST_OFFSET)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b),
        .done        (done),
        .result      (result)
    );

    mt_ram #(
        .WIDTH (MT_WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

endmodule

`default_nettype wire

// File: rtl/mt_checker.sv
// Port-level checker for the MT19937 generator, bound to the top level.
`default_nettype none

module mt_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire mt_pkg::req_t req,
    input wire logic         done,
    input wire mt_pkg::rsp_t result
);

    logic seen_seeded_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_seeded_reg <= 1'b0;
        end
        else if (done && result.seeded)
        begin
            seen_seeded_reg <= 1'b1;
        end
    end

    // unseeded beats carry a zero word
    a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.seeded |-> result.random_word == '0)
        else $error("unseeded result with nonzero word");

    // seeded draws need a RAM read, so they never come in adjacent cycles
    a_seeded_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.seeded |=> !done)
        else $error("seeded results in adjacent cycles");

    // once seeded, the generator stays seeded until reset
    a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done && seen_seeded_reg |-> result.seeded)
        else $error("unseeded result after a seeded one");

    // the queue only fills on an accepted beat
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && !$past(busy) && ($past(req.req_type) == 1'b0
                                                       || $past(req.req_type) == 1'b1))
        else $error("busy rose without an accepted beat");

endmodule

bind mersenne_twister_generator mt_checker u_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for mersenne_twister_generator: draws and reseeds checked against an MT19937 predictor.

module tb;

    import mt_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    rsp_t result;

    mersenne_twister_generator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    logic [31:0] mt_words [0:MT_STATE_WORDS-1];
    int          mt_pos;
    logic        mt_seeded;
    rsp_t        pending_words [$];
    int          error_count;
    int          beats_sent;
    bit          no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("** mersenne_twister_generator: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [31:0] temper_word(input logic [31:0] w);
        logic [31:0] v;
        v = w;
        v = v ^ (v >> 11);
        v = v ^ ((v << 7) & MT_TEMPER_B);
        v = v ^ ((v << 15) & MT_TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

    function automatic void mt_twist();
        int          k;
        int          far_idx;
        logic [31:0] y;
        for (k = 0; k < MT_STATE_WORDS; k++)
        begin
            far_idx = (k + MT_TWIST_OFFSET) % MT_STATE_WORDS;
            y = (mt_words[k] & MT_UPPER) | (mt_words[(k + 1) % MT_STATE_WORDS] & MT_LOWER);
            mt_words[k] = mt_words[far_idx] ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
        end
    endfunction

    function automatic void mt_reseed(input logic [31:0] s);
        int          k;
        logic [31:0] p;
        mt_words[0] = s;
        for (k = 1; k < MT_STATE_WORDS; k++)
        begin
            p = mt_words[k-1];
            mt_words[k] = MT_MULT * (p ^ (p >> 30)) + 32'(k);
        end
        mt_pos    = MT_STATE_WORDS;
        mt_seeded = 1'b1;
    endfunction

    function automatic rsp_t mt_draw();
        rsp_t r;
        r = '0;
        if (!mt_seeded)
            return r;
        if (mt_pos >= MT_STATE_WORDS)
        begin
            mt_twist();
            mt_pos = 0;
        end
        r.random_word = temper_word(mt_words[mt_pos]);
        r.seeded      = 1'b1;
        mt_pos++;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // one beat: hold start until the block takes it, then predict
    task automatic send_beat(input op_t op, input logic [31:0] s);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        req   <= {logic'(op), s};
        do
            @(posedge clk);
        while (busy !== 1'b0);
        beats_sent++;
        if (op == OP_RESEED)
            mt_reseed(s);
        else
            pending_words.push_back(mt_draw());
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            req   <= {1'($urandom), 32'($urandom)};
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic draw_words(input int n);
        repeat (n) send_beat(OP_DRAW, $urandom);
    endtask

    always @(posedge clk)
    begin : check_result
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
                report_mismatch($sformatf("result %h with no draw outstanding",
                                          result.random_word));
            else
            begin
                want = pending_words.pop_front();
                if (result.random_word !== want.random_word)
                    report_mismatch($sformatf("random_word %h, expected %h",
                                              result.random_word, want.random_word));
                if (result.seeded !== want.seeded)
                    report_mismatch($sformatf("seeded %b, expected %b",
                                              result.seeded, want.seeded));
            end
        end
    end

    task automatic test_unseeded();
        no_gaps = 1'b1;
        send_beat(OP_DRAW, 32'h0000_0000);
        send_beat(OP_DRAW, 32'hffff_ffff);
        no_gaps = 1'b0;
        send_beat(OP_DRAW, $urandom);
    endtask

    task automatic test_seed_extremes();
        send_beat(OP_RESEED, 32'h0000_0000);
        draw_words(3);
        send_beat(OP_RESEED, 32'hffff_ffff);
        draw_words(2);
        send_beat(OP_RESEED, 32'd5489);
        draw_words(2);
        no_gaps = 1'b1;
        send_beat(OP_RESEED, $urandom);
        send_beat(OP_RESEED, $urandom);
        draw_words(2);
        no_gaps = 1'b0;
        send_beat(OP_RESEED, $urandom);
        draw_words(1);
    endtask

    // long run without reseed, so the state twists again after the first sweep
    task automatic test_twist_wrap();
        send_beat(OP_RESEED, $urandom);
        no_gaps = 1'b1;
        draw_words(300);
        no_gaps = 1'b0;
        draw_words(400);
    endtask

    task automatic test_random_mix();
        int n;
        int r;
        int k;
        while (beats_sent < 1700)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            send_beat(OP_RESEED, $urandom);
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(1, 20);
            else if (r < 95)
                n = $urandom_range(21, 80);
            else
                n = $urandom_range(100, 200);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 99) < 3)
                    send_beat(OP_RESEED, $urandom);
                else
                    send_beat(OP_DRAW, $urandom);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int waited;
        start       = 1'b0;
        req         = '0;
        rst_n       = 1'b0;
        error_count = 0;
        beats_sent  = 0;
        no_gaps     = 1'b0;
        mt_pos      = MT_STATE_WORDS;
        mt_seeded   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_unseeded();
        test_seed_extremes();
        test_twist_wrap();
        test_random_mix();

        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (pending_words.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (700) @(posedge clk);
        if (pending_words.size() != 0)
            report_mismatch($sformatf("%0d draws never returned", pending_words.size()));

        if (error_count == 0)
            $display("** mersenne_twister_generator: PASSED **");
        else
            $display("** mersenne_twister_generator: FAILED **");
        $finish;
    end

endmodule
